// File: design/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_defines
// Assertion macros shared by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, codes and result type of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int POS_W = $clog2(CELL_COUNT);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W = 11;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] BLANK_GLYPH    = 8'h20;
  localparam logic [7:0] ATTR_RESET     = 8'h07;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] cell_index;
    logic [7:0]       glyph;
    logic [7:0]       cell_attribute;
    logic             last;
  } result_t;

  // Zero-extend or truncate a cursor position to the result index width.
  function automatic logic [IDX_W-1:0] to_index(input logic [POS_W-1:0] pos);
    logic [POS_W+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, pos};
    return wide[IDX_W-1:0];
  endfunction

endpackage

// File: design/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character stream to screen cell writes and clear commands.
// ----------------------------------------------------------------------------
// One character enters per cycle while the result queue has room. It is
// registered, decoded against the cursor (kept as linear position, row,
// column and row start, so no divide is needed) and its zero, one or two
// results are pushed into a four-entry result queue that feeds the output
// port; a result leaves only after the input register and a queue entry.
// Sustained rate is one character per cycle, limited by the single output
// transaction per cycle (a printed character that fills the screen yields
// two results and costs one extra output slot). The attribute register is
// written through cfg_* and should change only while the block is idle.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [10:0] cell_index, [18:11] glyph,
                                  // [26:19] cell_attribute, [31:27] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // input stage
  logic       s_valid_r, s_valid_nxt;
  logic [7:0] s_code_r;
  logic       stage_go;

  // cursor state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] row_start_r, row_start_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       attr_r;

  // result queue
  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        n_push;
  result_t           e0, e1;
  result_t           head;

  logic is_nl, is_bs, at_end, last_row, col_last, col_first;

  assign cfg_ready = 1'b1;

  // room for two results once this cycle settles
  assign stage_go  = s_valid_r && (cnt_r < QPTR_W'(3) + 3'd0);
  assign in_tready = !s_valid_r || stage_go;
  assign s_valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (stage_go ? 1'b0 : s_valid_r);

  assign is_nl     = (s_code_r == CODE_NEWLINE);
  assign is_bs     = (s_code_r == CODE_BACKSPACE);
  assign at_end    = (pos_r == POS_W'(CELL_COUNT - 1));
  assign last_row  = (row_r == ROW_W'(ROWS - 1));
  assign col_last  = (col_r == COL_W'(COLUMNS - 1));
  assign col_first = (col_r == '0);

  always_comb begin
    result_t clr;
    clr.kind           = KIND_CLEAR;
    clr.cell_index     = '0;
    clr.glyph          = BLANK_GLYPH;
    clr.cell_attribute = attr_r;
    clr.last           = 1'b1;

    pos_nxt       = pos_r;
    row_start_nxt = row_start_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    n_push        = 2'd0;
    e0            = clr;
    e1            = clr;

    if (is_nl) begin
      if (last_row) begin
        pos_nxt       = '0;
        row_start_nxt = '0;
        col_nxt       = '0;
        row_nxt       = '0;
        n_push        = 2'd1;
      end else begin
        pos_nxt       = row_start_r + POS_W'(COLUMNS);
        row_start_nxt = row_start_r + POS_W'(COLUMNS);
        col_nxt       = '0;
        row_nxt       = row_r + ROW_W'(1);
      end
    end else if (is_bs) begin
      if (pos_r != '0) begin
        pos_nxt       = pos_r - POS_W'(1);
        e0.kind       = KIND_WRITE;
        e0.cell_index = to_index(pos_r - POS_W'(1));
        e0.glyph      = BLANK_GLYPH;
        e0.last       = 1'b1;
        n_push        = 2'd1;
        if (col_first) begin
          col_nxt       = COL_W'(COLUMNS - 1);
          row_nxt       = row_r - ROW_W'(1);
          row_start_nxt = row_start_r - POS_W'(COLUMNS);
        end else begin
          col_nxt = col_r - COL_W'(1);
        end
      end
    end else begin
      e0.kind       = KIND_WRITE;
      e0.cell_index = to_index(pos_r);
      e0.glyph      = s_code_r;
      e0.last       = !at_end;
      if (at_end) begin
        pos_nxt       = '0;
        row_start_nxt = '0;
        col_nxt       = '0;
        row_nxt       = '0;
        n_push        = 2'd2;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        n_push  = 2'd1;
        if (col_last) begin
          col_nxt       = '0;
          row_nxt       = row_r + ROW_W'(1);
          row_start_nxt = row_start_r + POS_W'(COLUMNS);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {5'd0, head.cell_attribute, head.glyph, head.cell_index};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (stage_go) begin
      cnt_nxt = cnt_nxt + {1'b0, n_push};
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      pos_r       <= '0;
      row_start_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= ATTR_RESET;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      s_valid_r <= s_valid_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      if (stage_go) begin
        pos_r       <= pos_nxt;
        row_start_r <= row_start_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        wr_ptr_r    <= wr_ptr_r + QPTR_W'(n_push);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // payload: input register and queue entries
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_code_r <= in_tdata;
    end
    if (stage_go && (n_push != 2'd0)) begin
      q_r[wr_ptr_r] <= e0;
    end
    if (stage_go && (n_push == 2'd2)) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= e1;
    end
  end

  `TCW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (QPTR_W+1)'(QDEPTH), "result queue overflow")
  `TCW_ASSERT_NOW(a_cursor_sum, 1'b1, pos_r == row_start_r + POS_W'(col_r), "cursor parts disagree")
  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (pos_r < POS_W'(CELL_COUNT)) && (col_r < COL_W'(COLUMNS)) && (row_r < ROW_W'(ROWS)), "cursor out of screen")
  `TCW_ASSERT_NEXT(a_wrap_zero, stage_go && (n_push == 2'd2), pos_r == '0, "cursor not home after screen wrap")

endmodule
